// ===== hw/rtl/dssm_pkg.sv =====
// shared constants, codes and control types for the dual stack block
package dssm_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int COUNT_W = 5;
    localparam int DATA_W  = 8;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_PEEK = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic accept;    // request taken this cycle, execute it
        logic load_out;  // move the finished result into the output register
    } cmd_t;

endpackage

// ===== hw/rtl/dssm_ctrl.sv =====
// controller: request sequencing and output register handshake
module dssm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output dssm_pkg::cmd_t cmd
);
    import dssm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.accept     = 1'b0;
        cmd.load_out   = 1'b0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // memory read data is ready now; wait for a free output slot
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == S_EXEC))
        else $error("accepted request did not move to execute");
    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not presented");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !cmd.load_out)
        else $error("pending word overwritten");
`endif

endmodule

// ===== hw/rtl/dssm_datapath.sv =====
// datapath: shared byte store, stack fill counters and result register
module dssm_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dssm_pkg::cmd_t                cmd,
    input  logic [1:0]                    kind,
    input  logic                          which_stack,
    input  logic [dssm_pkg::DATA_W-1:0]   write_data,
    output logic [dssm_pkg::DATA_W-1:0]   read_data,
    output logic [1:0]                    status,
    output logic [dssm_pkg::COUNT_W-1:0]  lower_count,
    output logic [dssm_pkg::COUNT_W-1:0]  upper_count
);
    import dssm_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [FILL_W-1:0]  lower_fill_reg, lower_fill_next;
    logic [FILL_W-1:0]  upper_fill_reg, upper_fill_next;
    logic [DATA_W-1:0]  mem_rd_reg;
    logic               read_ok_reg;
    status_t            status_reg, status_next;

    logic [DATA_W-1:0]  read_data_reg;
    logic [1:0]         status_out_reg;
    logic [COUNT_W-1:0] lower_count_reg;
    logic [COUNT_W-1:0] upper_count_reg;

    logic [FILL_W-1:0]  sel_fill;
    logic [FILL_W-1:0]  pos;
    logic [FILL_W:0]    total;
    logic [ADDR_W-1:0]  slot;
    logic               is_push, is_pop, is_read;
    logic               full, empty;
    logic               do_write, do_pop, read_ok;

    always_comb begin
        sel_fill = which_stack ? upper_fill_reg : lower_fill_reg;
        is_push  = (kind == KIND_PUSH);
        is_pop   = (kind == KIND_POP);
        is_read  = is_pop || (kind == KIND_PEEK);
        total    = {1'b0, lower_fill_reg} + {1'b0, upper_fill_reg};
        full     = (total >= (FILL_W + 1)'(DEPTH));
        empty    = (sel_fill == '0);
        // push goes to the next free entry, pop and peek use the top entry
        pos      = is_push ? sel_fill : sel_fill - 1'b1;
        slot     = which_stack ? ADDR_W'(DEPTH - 1) - pos[ADDR_W-1:0] : pos[ADDR_W-1:0];
        do_write = cmd.accept && is_push && !full;
        do_pop   = cmd.accept && is_pop && !empty;
        read_ok  = is_read && !empty;
    end

    always_comb begin
        case (kind) inside
            KIND_PUSH:           status_next = full ? ST_FULL : ST_OK;
            KIND_POP, KIND_PEEK: status_next = empty ? ST_EMPTY : ST_OK;
            default:             status_next = ST_OK;
        endcase
    end

    always_comb begin
        lower_fill_next = lower_fill_reg;
        upper_fill_next = upper_fill_reg;
        if (do_write) begin
            if (which_stack) upper_fill_next = upper_fill_reg + 1'b1;
            else             lower_fill_next = lower_fill_reg + 1'b1;
        end else if (do_pop) begin
            if (which_stack) upper_fill_next = upper_fill_reg - 1'b1;
            else             lower_fill_next = lower_fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[slot] <= write_data;
        end
        if (cmd.accept) begin
            mem_rd_reg <= mem[slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_fill_reg <= '0;
            upper_fill_reg <= '0;
        end else begin
            lower_fill_reg <= lower_fill_next;
            upper_fill_reg <= upper_fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            read_ok_reg <= read_ok;
            status_reg  <= status_next;
        end
        if (cmd.load_out) begin
            read_data_reg   <= read_ok_reg ? mem_rd_reg : '0;
            status_out_reg  <= status_reg;
            lower_count_reg <= COUNT_W'(lower_fill_reg);
            upper_count_reg <= COUNT_W'(upper_fill_reg);
        end
    end

    assign read_data   = read_data_reg;
    assign status      = status_out_reg;
    assign lower_count = lower_count_reg;
    assign upper_count = upper_count_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total <= (FILL_W + 1)'(DEPTH))
        else $error("stacks hold more entries than the store");
    a_fill_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.accept |=> ($stable(lower_fill_reg) && $stable(upper_fill_reg)))
        else $error("fill changed without a request");
    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && is_push && full) |=> (status_reg == ST_FULL
            && $stable(lower_fill_reg) && $stable(upper_fill_reg)))
        else $error("push into full store changed state");
`endif

endmodule

// ===== hw/rtl/dual_stack_shared_memory.sv =====
// top level: two byte stacks sharing one store, stream request and result ports
//
// s_ channel carries one request per word: tuser holds the operation and the
// stack select, tdata the byte to push. m_ channel returns one result word per
// request, in order: tdata holds the read byte and both stack fills after the
// request, tuser the status code.
// Lower stack grows up from entry 0, upper stack grows down from the last
// entry; a push is refused only when both together fill the store.
// The result is registered: an accepted request reads the shared store into a
// register, and the output register is loaded from it once that register is free.
// A new request is taken only after the last one has loaded its result.
// While a result waits on m_tready the block takes the next request and holds
// it finished until the output register frees up.
// Reset (aresetn low, synchronous) empties both stacks and drops m_tvalid;
// store contents are not cleared, and an entry is never returned before being written.
module dual_stack_shared_memory (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // write_data[7:0]
    input  logic [2:0]  s_tuser,   // kind[1:0], which_stack[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_data[7:0], lower_count[12:8], upper_count[17:13]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import dssm_pkg::*;

    cmd_t               cmd;
    logic [DATA_W-1:0]  read_data;
    logic [1:0]         status;
    logic [COUNT_W-1:0] lower_count;
    logic [COUNT_W-1:0] upper_count;

    dssm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dssm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .kind        (s_tuser[1:0]),
        .which_stack (s_tuser[2]),
        .write_data  (s_tdata),
        .read_data   (read_data),
        .status      (status),
        .lower_count (lower_count),
        .upper_count (upper_count)
    );

    assign m_tdata = {6'd0, upper_count, lower_count, read_data};
    assign m_tuser = status;

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the dual stack block: directed and random requests checked against a stack predictor
module tb_top;
    import dssm_pkg::*;

    // kind value with no operation behind it
    localparam logic [1:0] KIND_NOP = 2'd3;
    localparam int SETTLE_CYCLES = 10;
    localparam int WORDS_PER_PHASE = 470;

    typedef struct packed {
        logic [7:0] read_data;
        status_t    status;
        logic [4:0] lower_count;
        logic [4:0] upper_count;
    } stack_result_t;

    class stack_scoreboard;
        logic [7:0]    store [DEPTH];
        int            lower_fill;
        int            upper_fill;
        stack_result_t expected_q [$];
        int            mismatches;

        function new();
            lower_fill = 0;
            upper_fill = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report(string msg);
            if (mismatches < 40)
                $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endfunction

        // run one request through the stack state and queue its result
        function void note_request(logic [1:0] kind, logic which, logic [7:0] wdata);
            stack_result_t res;
            int            fill;
            int            slot;
            res.read_data = 8'd0;
            res.status    = ST_OK;
            fill = which ? upper_fill : lower_fill;
            case (kind) inside
                KIND_PUSH: begin
                    if (lower_fill + upper_fill >= DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        slot = which ? DEPTH - 1 - fill : fill;
                        store[slot] = wdata;
                        fill++;
                    end
                end
                KIND_POP, KIND_PEEK: begin
                    if (fill == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        slot = which ? DEPTH - fill : fill - 1;
                        res.read_data = store[slot];
                        if (kind == KIND_POP)
                            fill--;
                    end
                end
                default: ;
            endcase
            if (which)
                upper_fill = fill;
            else
                lower_fill = fill;
            res.lower_count = lower_fill[4:0];
            res.upper_count = upper_fill[4:0];
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [7:0] rd, logic [1:0] status,
                                   logic [4:0] lower_cnt, logic [4:0] upper_cnt);
            stack_result_t want;
            if (expected_q.size() == 0) begin
                report("result word with no request pending");
                return;
            end
            want = expected_q.pop_front();
            if (rd !== want.read_data)
                report($sformatf("read_data %0h, want %0h", rd, want.read_data));
            if (status !== want.status)
                report($sformatf("status %0d, want %0d", status, want.status));
            if (lower_cnt !== want.lower_count)
                report($sformatf("lower_count %0d, want %0d", lower_cnt, want.lower_count));
            if (upper_cnt !== want.upper_count)
                report($sformatf("upper_count %0d, want %0d", upper_cnt, want.upper_count));
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic [2:0]  s_tuser  = 3'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    int idle_pct  = 0;
    int stall_pct = 0;

    stack_scoreboard sb = new();

    dual_stack_shared_memory u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tuser[1:0], s_tuser[2], s_tdata);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[7:0], m_tuser, m_tdata[12:8], m_tdata[17:13]);
    end

    task automatic send_request(input logic [1:0] kind, input logic which,
                                input logic [7:0] wdata);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {which, kind};
        s_tdata  <= wdata;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold the sender until every queued result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic run_directed();
        send_request(KIND_POP, 1'b0, 8'h5A);
        send_request(KIND_PEEK, 1'b1, 8'hA5);
        send_request(KIND_NOP, 1'b1, 8'hFF);
        send_request(KIND_PUSH, 1'b0, 8'hFF);
        send_request(KIND_PUSH, 1'b1, 8'h00);
        send_request(KIND_PEEK, 1'b0, 8'h00);
        send_request(KIND_POP, 1'b0, 8'h00);
        // upper stack alone takes the whole store down to entry 0
        for (int i = 0; i < 15; i++)
            send_request(KIND_PUSH, 1'b1, 8'h80 ^ 8'(i * 17));
        send_request(KIND_PUSH, 1'b0, 8'h55);
        send_request(KIND_POP, 1'b1, 8'h00);
        send_request(KIND_PEEK, 1'b1, 8'h00);
    endtask

    // runs of push-heavy, balanced or pop-heavy traffic so fills sweep end to end
    task automatic run_random(input int count);
        int         stack_mode;
        int         push_pct;
        int         run_left;
        logic [1:0] kind;
        logic       which;
        run_left   = 0;
        stack_mode = 2;
        push_pct   = 50;
        for (int i = 0; i < count; i++) begin
            if (run_left == 0) begin
                stack_mode = $urandom_range(2);
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
                run_left = $urandom_range(20, 60);
            end
            run_left--;
            if ($urandom_range(99) < 3)
                kind = KIND_NOP;
            else if ($urandom_range(99) < push_pct)
                kind = KIND_PUSH;
            else if ($urandom_range(2) == 0)
                kind = KIND_PEEK;
            else
                kind = KIND_POP;
            which = (stack_mode == 2) ? 1'($urandom_range(1)) : 1'(stack_mode);
            send_request(kind, which, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_random(WORDS_PER_PHASE);
        drain();

        idle_pct = 78;
        run_random(WORDS_PER_PHASE);
        drain();

        idle_pct  = 0;
        stall_pct = 78;
        run_random(WORDS_PER_PHASE);
        drain();

        idle_pct  = 22;
        stall_pct = 22;
        run_random(WORDS_PER_PHASE);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatches == 0) begin
            $display("[dual_stack_shared_memory] OK");
        end else begin
            $display("[dual_stack_shared_memory] ERROR");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("[dual_stack_shared_memory] ERROR");
        $finish;
    end

endmodule
